>>> rtl/assert_macros.svh
// assertion helpers, clocked on i_clk and quiet while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define DFPR_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

`define DFPR_ASSERT_NEXT(label, cond, conseq) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (conseq)) \
        else $error("assertion failed");

`endif

>>> rtl/dfpr_pkg.sv
package dfpr_pkg;

    localparam int PACKETS_PER_FRAME = 16;
    localparam int PIXELS_PER_PACKET = 32;
    localparam int MAX_PAYLOAD_BYTES = 64;
    localparam int HDR_BYTES         = 8;
    localparam int CRC_BYTES         = 4;
    localparam int CAPACITY          = HDR_BYTES + MAX_PAYLOAD_BYTES + CRC_BYTES;

    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(MAX_PAYLOAD_BYTES);
    localparam int NPIX_MAX = (MAX_PAYLOAD_BYTES + 1) / 2;
    localparam int NPIX_W   = $clog2(NPIX_MAX + 1);
    localparam int POS_W    = (COUNT_W > NPIX_W + 1) ? COUNT_W : NPIX_W + 1;
    localparam int RCNT_W   = $clog2(PACKETS_PER_FRAME + 1);
    localparam int PIDX_W   = (PACKETS_PER_FRAME > 1) ? $clog2(PACKETS_PER_FRAME) : 1;
    localparam int INDEX_W  = 9;

    localparam logic [31:0] CRC_SEED    = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] STALE_LIMIT = 32'h8000_0000;

    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_CRC_FAIL  = 3'd2;
    localparam logic [2:0] ST_NUM_HIGH  = 3'd3;
    localparam logic [2:0] ST_DUPLICATE = 3'd4;
    localparam logic [2:0] ST_STALE     = 3'd5;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    typedef struct packed {
        logic byte_en;
        logic eval;
        logic fetch;
        logic pixel;
        logic restart;
    } t_ctl_cmd;

    typedef struct packed {
        logic out_free;
        logic reject;
        logic no_pix;
        logic last_pix;
    } t_ctl_sts;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/dfpr_if.sv
interface dfpr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_packet;

    modport source (output valid, output data_byte, output end_of_packet, input ready);
    modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface dfpr_out_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [2:0]  packet_status;
    logic [31:0] frame_number;
    logic        frame_complete;
    logic        clear_image;
    logic [8:0]  pixel_index;
    logic [15:0] pixel_value;
    logic        last_of_run;

    modport source (output valid, output item_kind, output packet_status,
                    output frame_number, output frame_complete, output clear_image,
                    output pixel_index, output pixel_value, output last_of_run,
                    input ready);
    modport sink   (input valid, input item_kind, input packet_status,
                    input frame_number, input frame_complete, input clear_image,
                    input pixel_index, input pixel_value, input last_of_run,
                    output ready);
endinterface

>>> rtl/dfpr_datapath.sv
`include "assert_macros.svh"

module dfpr_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_data_byte,
    input  dfpr_pkg::t_ctl_cmd  i_cmd,
    output dfpr_pkg::t_ctl_sts  o_sts,
    dfpr_out_if.source          o_out
);

    localparam int COUNT_W = dfpr_pkg::COUNT_W;
    localparam int NPIX_W  = dfpr_pkg::NPIX_W;
    localparam int RCNT_W  = dfpr_pkg::RCNT_W;
    localparam int PIDX_W  = dfpr_pkg::PIDX_W;
    localparam int ADDR_W  = dfpr_pkg::ADDR_W;
    localparam int POS_W   = dfpr_pkg::POS_W;
    localparam int INDEX_W = dfpr_pkg::INDEX_W;
    localparam int PPF     = dfpr_pkg::PACKETS_PER_FRAME;

    logic [31:0]        r_crc;
    logic [31:0]        r_window;
    logic [COUNT_W-1:0] r_count;
    logic [63:0]        r_header;
    logic [7:0]         r_mem [dfpr_pkg::MAX_PAYLOAD_BYTES];
    logic [31:0]        r_cur_frame;
    logic [RCNT_W-1:0]  r_rcv_count;
    logic [PPF-1:0]     r_rcv_mask;

    logic [7:0]         r_rd_hi;
    logic [7:0]         r_rd_lo;
    logic [NPIX_W-1:0]  r_npix;
    logic [NPIX_W-1:0]  r_k;
    logic [COUNT_W-1:0] r_n;
    logic [INDEX_W-1:0] r_pix_index;
    logic [31:0]        r_frame_hold;

    logic               r_out_valid;
    logic               r_out_kind;
    logic [2:0]         r_out_status;
    logic [31:0]        r_out_frame;
    logic               r_out_complete;
    logic               r_out_clear;
    logic [INDEX_W-1:0] r_out_index;
    logic [15:0]        r_out_value;
    logic               r_out_last;

    logic [31:0]        w_frame;
    logic [31:0]        w_pnum;
    logic [PIDX_W-1:0]  w_pidx;
    logic [31:0]        w_diff;
    logic               w_same;
    logic [2:0]         w_status;
    logic               w_reject;
    logic [RCNT_W-1:0]  w_rcv_next;
    logic [PPF-1:0]     w_onehot;
    logic [COUNT_W-1:0] w_n;
    logic [COUNT_W-1:0] w_n_plus;
    logic [NPIX_W-1:0]  w_npix;
    logic [INDEX_W-1:0] w_pix_base;
    logic               w_last_pix;
    logic [POS_W-1:0]   w_lo_pos;
    logic [7:0]         w_lo;
    logic [ADDR_W-1:0]  w_wr_addr;
    logic [ADDR_W-1:0]  w_rd_addr_hi;
    logic [ADDR_W-1:0]  w_rd_addr_lo;
    logic               w_in_cap;
    logic               w_in_payload;

    // header fields and packet verdict
    always_comb begin
        w_frame  = r_header[63:32];
        w_pnum   = r_header[31:0];
        w_pidx   = w_pnum[PIDX_W-1:0];
        w_diff   = w_frame - r_cur_frame;
        w_same   = (r_rcv_count != '0) && (w_frame == r_cur_frame);
        w_status = dfpr_pkg::ST_ACCEPTED;
        if (r_count < COUNT_W'(dfpr_pkg::HDR_BYTES + dfpr_pkg::CRC_BYTES)) begin
            w_status = dfpr_pkg::ST_SHORT;
        end else if (~r_crc != r_window) begin
            w_status = dfpr_pkg::ST_CRC_FAIL;
        end else if (w_pnum >= 32'(PPF)) begin
            w_status = dfpr_pkg::ST_NUM_HIGH;
        end else if (w_same) begin
            if (r_rcv_mask[w_pidx]) begin
                w_status = dfpr_pkg::ST_DUPLICATE;
            end
        end else if (w_diff > dfpr_pkg::STALE_LIMIT) begin
            w_status = dfpr_pkg::ST_STALE;
        end
        w_reject   = (w_status != dfpr_pkg::ST_ACCEPTED);
        w_rcv_next = (w_same ? r_rcv_count : RCNT_W'(0)) + RCNT_W'(1);
        w_onehot   = '0;
        w_onehot[w_pidx] = 1'b1;
        w_n        = r_count - COUNT_W'(dfpr_pkg::HDR_BYTES + dfpr_pkg::CRC_BYTES);
        w_n_plus   = w_n + COUNT_W'(1);
        w_npix     = NPIX_W'(w_n_plus >> 1);
        w_pix_base = INDEX_W'(w_pnum[INDEX_W-1:0] * INDEX_W'(dfpr_pkg::PIXELS_PER_PACKET));
    end

    // pixel assembly, odd tail pairs with the first crc byte
    always_comb begin
        w_last_pix   = (r_k == r_npix - NPIX_W'(1));
        w_lo_pos     = POS_W'({r_k, 1'b1});
        w_lo         = (w_lo_pos < POS_W'(r_n)) ? r_rd_lo : r_window[31:24];
        w_rd_addr_hi = ADDR_W'({r_k, 1'b0});
        w_rd_addr_lo = ADDR_W'({r_k, 1'b1});
        w_wr_addr    = ADDR_W'(r_count - COUNT_W'(dfpr_pkg::HDR_BYTES));
        w_in_cap     = (r_count < COUNT_W'(dfpr_pkg::CAPACITY));
        w_in_payload = (r_count >= COUNT_W'(dfpr_pkg::HDR_BYTES))
                    && (r_count < COUNT_W'(dfpr_pkg::HDR_BYTES
                                           + dfpr_pkg::MAX_PAYLOAD_BYTES));
    end

    assign o_sts.out_free = !r_out_valid || o_out.ready;
    assign o_sts.reject   = w_reject;
    assign o_sts.no_pix   = (w_npix == '0);
    assign o_sts.last_pix = w_last_pix;

    // datagram receive state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_crc    <= dfpr_pkg::CRC_SEED;
            r_window <= '0;
            r_count  <= '0;
            r_header <= '0;
        end else if (i_cmd.byte_en && w_in_cap) begin
            if (r_count >= COUNT_W'(dfpr_pkg::CRC_BYTES)) begin
                r_crc <= dfpr_pkg::crc_byte(r_crc, r_window[31:24]);
            end
            r_window <= {r_window[23:0], i_data_byte};
            if (r_count < COUNT_W'(dfpr_pkg::HDR_BYTES)) begin
                r_header <= {r_header[55:0], i_data_byte};
            end
            r_count <= r_count + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_en && w_in_cap && w_in_payload) begin
            r_mem[w_wr_addr] <= i_data_byte;
        end
        if (i_cmd.fetch) begin
            r_rd_hi <= r_mem[w_rd_addr_hi];
            r_rd_lo <= r_mem[w_rd_addr_lo];
        end
    end

    // frame tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_frame <= '0;
            r_rcv_count <= '0;
            r_rcv_mask  <= '0;
        end else if (i_cmd.eval && !w_reject) begin
            r_cur_frame <= w_frame;
            r_rcv_count <= w_rcv_next;
            r_rcv_mask  <= (w_same ? r_rcv_mask : '0) | w_onehot;
        end
    end

    // pixel run bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_npix       <= w_npix;
            r_n          <= w_n;
            r_k          <= '0;
            r_pix_index  <= w_pix_base;
            r_frame_hold <= w_frame;
        end else if (i_cmd.pixel) begin
            r_k         <= r_k + NPIX_W'(1);
            r_pix_index <= r_pix_index + INDEX_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.eval || i_cmd.pixel) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_out_kind     <= dfpr_pkg::KIND_STATUS;
            r_out_status   <= w_status;
            r_out_frame    <= w_reject ? 32'd0 : w_frame;
            r_out_complete <= !w_reject && (w_rcv_next == RCNT_W'(PPF));
            r_out_clear    <= !w_reject && (w_rcv_next == RCNT_W'(1));
            r_out_index    <= '0;
            r_out_value    <= '0;
            r_out_last     <= w_reject || (w_npix == '0);
        end else if (i_cmd.pixel) begin
            r_out_kind     <= dfpr_pkg::KIND_PIXEL;
            r_out_status   <= dfpr_pkg::ST_ACCEPTED;
            r_out_frame    <= r_frame_hold;
            r_out_complete <= 1'b0;
            r_out_clear    <= 1'b0;
            r_out_index    <= r_pix_index;
            r_out_value    <= {r_rd_hi, w_lo};
            r_out_last     <= w_last_pix;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.item_kind      = r_out_kind;
    assign o_out.packet_status  = r_out_status;
    assign o_out.frame_number   = r_out_frame;
    assign o_out.frame_complete = r_out_complete;
    assign o_out.clear_image    = r_out_clear;
    assign o_out.pixel_index    = r_out_index;
    assign o_out.pixel_value    = r_out_value;
    assign o_out.last_of_run    = r_out_last;

    `DFPR_ASSERT(a_count_cap, r_count <= COUNT_W'(dfpr_pkg::CAPACITY))
    `DFPR_ASSERT(a_mask_matches_count, $countones(r_rcv_mask) == int'(r_rcv_count))
    `DFPR_ASSERT(a_pixel_in_run, i_cmd.pixel |-> (r_k < r_npix))

endmodule

>>> rtl/dfpr_ctrl.sv
`include "assert_macros.svh"

module dfpr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_eop,
    output logic                o_in_ready,
    input  dfpr_pkg::t_ctl_sts  i_sts,
    output dfpr_pkg::t_ctl_cmd  o_cmd
);

    localparam logic [1:0] S_RECV  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;
    localparam logic [1:0] S_PIXEL = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_RECV: begin
                o_in_ready    = 1'b1;
                o_cmd.byte_en = i_in_valid;
                if (i_in_valid && i_in_eop) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.out_free) begin
                    o_cmd.eval = 1'b1;
                    if (i_sts.reject || i_sts.no_pix) begin
                        o_cmd.restart = 1'b1;
                        n_state       = S_RECV;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_PIXEL;
            end
            S_PIXEL: begin
                if (i_sts.out_free) begin
                    o_cmd.pixel = 1'b1;
                    if (i_sts.last_pix) begin
                        o_cmd.restart = 1'b1;
                        n_state       = S_RECV;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            default: begin
                n_state = S_RECV;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RECV;
        end else begin
            r_state <= n_state;
        end
    end

    `DFPR_ASSERT_NEXT(a_eop_blocks_input, i_in_valid && o_in_ready && i_in_eop, !o_in_ready)
    `DFPR_ASSERT(a_cmd_exclusive, $onehot0({o_cmd.byte_en, o_cmd.eval, o_cmd.fetch, o_cmd.pixel}))
    `DFPR_ASSERT(a_restart_at_end, o_cmd.restart |-> (o_cmd.eval || o_cmd.pixel))

endmodule

>>> rtl/depth_frame_packet_reassembler_unit.sv
// once the end-of-packet beat is accepted the controller enters its eval state, which loads
// the status item into the output register when it is free; one byte beat per cycle inside a
// datagram; each pixel takes a fetch and a pixel state; input ready is low until the last item
// is issued; the output register lets the sink stall; the pixel sequencer waits on it
// reset: synchronous, active low; clears crc, window, header, frame state and the output valid
// the payload buffer is not cleared; each byte used in a pixel value is written before it is read

module depth_frame_packet_reassembler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dfpr_in_if.sink     i_in,
    dfpr_out_if.source  o_out
);

    dfpr_pkg::t_ctl_cmd w_cmd;
    dfpr_pkg::t_ctl_sts w_sts;
    logic               w_in_ready;

    assign i_in.ready = w_in_ready;

    dfpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_eop   (i_in.end_of_packet),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    dfpr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (i_in.data_byte),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out       (o_out)
    );

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [31:0] frame;
        logic        complete;
        logic        clear;
        logic [8:0]  index;
        logic [15:0] value;
        logic        last;
    } t_depth_item;

    class t_frame_scoreboard;
        bit [31:0]                            crc_acc;
        bit [31:0]                            window;
        int unsigned                          nbytes;
        bit [63:0]                            header;
        bit [7:0]                             payload [dfpr_pkg::MAX_PAYLOAD_BYTES];
        bit [31:0]                            cur_frame;
        int unsigned                          rx_count;
        bit [dfpr_pkg::PACKETS_PER_FRAME-1:0] rx_mask;
        t_depth_item                          pending [$];
        int unsigned                          errors;

        function new();
            restart();
            cur_frame = '0;
            rx_count  = 0;
            rx_mask   = '0;
            errors    = 0;
        endfunction

        static function bit [31:0] crc_next(bit [31:0] c, bit [7:0] d);
            bit [31:0] r;
            r = c ^ {24'd0, d};
            for (int k = 0; k < 8; k++) begin
                r = r[0] ? ((r >> 1) ^ dfpr_pkg::CRC_POLY) : (r >> 1);
            end
            return r;
        endfunction

        function void restart();
            crc_acc = dfpr_pkg::CRC_SEED;
            window  = '0;
            nbytes  = 0;
            header  = '0;
        endfunction

        function void push(bit kind, bit [2:0] st, bit [31:0] fr, bit cmp, bit clr,
                           bit [8:0] idx, bit [15:0] val, bit last);
            t_depth_item it;
            it.kind     = kind;
            it.status   = st;
            it.frame    = fr;
            it.complete = cmp;
            it.clear    = clr;
            it.index    = idx;
            it.value    = val;
            it.last     = last;
            pending.push_back(it);
        endfunction

        // accepted input beat: advance the packet state, predict items at end of packet
        function void note_byte(bit [7:0] b, bit eop);
            int unsigned pos;
            int unsigned n;
            int unsigned npix;
            bit [31:0]   fr;
            bit [31:0]   pn;
            bit [2:0]    st;
            bit [7:0]    lo;
            if (nbytes < dfpr_pkg::CAPACITY) begin
                pos = nbytes;
                if (pos >= dfpr_pkg::CRC_BYTES)
                    crc_acc = crc_next(crc_acc, window[31:24]);
                window = {window[23:0], b};
                if (pos < dfpr_pkg::HDR_BYTES)
                    header = {header[55:0], b};
                else if (pos - dfpr_pkg::HDR_BYTES < dfpr_pkg::MAX_PAYLOAD_BYTES)
                    payload[pos - dfpr_pkg::HDR_BYTES] = b;
                nbytes = pos + 1;
            end
            if (!eop)
                return;

            fr = header[63:32];
            pn = header[31:0];
            st = dfpr_pkg::ST_ACCEPTED;
            if (nbytes < dfpr_pkg::HDR_BYTES + dfpr_pkg::CRC_BYTES)
                st = dfpr_pkg::ST_SHORT;
            else if (~crc_acc != window)
                st = dfpr_pkg::ST_CRC_FAIL;
            else if (pn >= dfpr_pkg::PACKETS_PER_FRAME)
                st = dfpr_pkg::ST_NUM_HIGH;
            else if (rx_count > 0 && fr == cur_frame) begin
                if (rx_mask[pn])
                    st = dfpr_pkg::ST_DUPLICATE;
            end else if (32'(fr - cur_frame) > dfpr_pkg::STALE_LIMIT) begin
                st = dfpr_pkg::ST_STALE;
            end else begin
                cur_frame = fr;
                rx_count  = 0;
                rx_mask   = '0;
            end

            if (st != dfpr_pkg::ST_ACCEPTED) begin
                push(dfpr_pkg::KIND_STATUS, st, '0, 1'b0, 1'b0, '0, '0, 1'b1);
                restart();
                return;
            end

            rx_count++;
            rx_mask[pn] = 1'b1;
            n    = nbytes - dfpr_pkg::HDR_BYTES - dfpr_pkg::CRC_BYTES;
            npix = (n + 1) / 2;
            push(dfpr_pkg::KIND_STATUS, dfpr_pkg::ST_ACCEPTED, fr,
                 rx_count == dfpr_pkg::PACKETS_PER_FRAME, rx_count == 1, '0, '0, npix == 0);
            for (int unsigned k = 0; k < npix; k++) begin
                lo = (2 * k + 1 < n) ? payload[2 * k + 1] : window[31:24];
                push(dfpr_pkg::KIND_PIXEL, dfpr_pkg::ST_ACCEPTED, fr, 1'b0, 1'b0,
                     9'(pn * dfpr_pkg::PIXELS_PER_PACKET + k), {payload[2 * k], lo},
                     k + 1 == npix);
            end
            restart();
        endfunction

        task report(string what);
            errors++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_item(t_depth_item got);
            t_depth_item want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected item kind %0d status %0d index %0d",
                                 got.kind, got.status, got.index));
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("item_kind %0d, want %0d", got.kind, want.kind));
            if (got.status !== want.status)
                report($sformatf("packet_status %0d, want %0d", got.status, want.status));
            if (got.frame !== want.frame)
                report($sformatf("frame_number %h, want %h", got.frame, want.frame));
            if (got.complete !== want.complete)
                report($sformatf("frame_complete %0d, want %0d", got.complete, want.complete));
            if (got.clear !== want.clear)
                report($sformatf("clear_image %0d, want %0d", got.clear, want.clear));
            if (got.index !== want.index)
                report($sformatf("pixel_index %0d, want %0d", got.index, want.index));
            if (got.value !== want.value)
                report($sformatf("pixel_value %h, want %h", got.value, want.value));
            if (got.last !== want.last)
                report($sformatf("last_of_run %0d, want %0d", got.last, want.last));
        endtask
    endclass

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_BYTES = 30;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dfpr_in_if  in_if ();
    dfpr_out_if out_if ();

    depth_frame_packet_reassembler_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_frame_scoreboard sb = new();

    int          in_idle_pct;
    int          out_idle_pct;
    int          idle_cycles = 0;
    int unsigned sent_bytes;
    bit [7:0]    dgram [$];
    bit [31:0]   gen_frame;
    int          remaining [$];

    always #5 i_clk = ~i_clk;

    // sink side: random backpressure and result checking
    always @(posedge i_clk) begin
        t_depth_item got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.kind     = out_if.item_kind;
            got.status   = out_if.packet_status;
            got.frame    = out_if.frame_number;
            got.complete = out_if.frame_complete;
            got.clear    = out_if.clear_image;
            got.index    = out_if.pixel_index;
            got.value    = out_if.pixel_value;
            got.last     = out_if.last_of_run;
            sb.check_item(got);
        end
        out_if.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function void make_packet(bit [31:0] fr, bit [31:0] pn, int plen, int fill);
        bit [31:0] crc;
        dgram.delete();
        for (int i = 3; i >= 0; i--)
            dgram.push_back(fr[8 * i +: 8]);
        for (int i = 3; i >= 0; i--)
            dgram.push_back(pn[8 * i +: 8]);
        for (int i = 0; i < plen; i++)
            dgram.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
        crc = dfpr_pkg::CRC_SEED;
        foreach (dgram[i])
            crc = t_frame_scoreboard::crc_next(crc, dgram[i]);
        crc = ~crc;
        for (int i = 3; i >= 0; i--)
            dgram.push_back(crc[8 * i +: 8]);
    endfunction

    function void make_noise(int len, int fill);
        dgram.delete();
        for (int i = 0; i < len; i++)
            dgram.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    endfunction

    function void corrupt_packet();
        int i;
        i = $urandom_range(0, dgram.size() - 1);
        dgram[i] ^= 8'(1 << $urandom_range(0, 7));
    endfunction

    function void add_overflow(int extra);
        for (int i = 0; i < extra; i++)
            dgram.push_back(8'($urandom));
    endfunction

    function void refill_frame();
        remaining.delete();
        for (int i = 0; i < dfpr_pkg::PACKETS_PER_FRAME; i++)
            remaining.push_back(i);
    endfunction

    function int pick_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, dfpr_pkg::MAX_PAYLOAD_BYTES);
        return $urandom_range(0, 8);
    endfunction

    task automatic send_beat(input bit [7:0] b, input bit eop);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_if.valid         <= 1'b0;
            in_if.data_byte     <= 8'($urandom);
            in_if.end_of_packet <= 1'($urandom);
            @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.data_byte     <= b;
        in_if.end_of_packet <= eop;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_byte(b, eop);
    endtask

    task automatic send_datagram();
        foreach (dgram[i])
            send_beat(dgram[i], i == dgram.size() - 1);
        sent_bytes += dgram.size();
    endtask

    task automatic random_datagram();
        int r;
        int idx;
        int pn;
        r = $urandom_range(0, 99);
        if (r < 62 || (r >= 70 && r < 78)) begin
            if (remaining.size() == 0) begin
                gen_frame = gen_frame + 1;
                refill_frame();
            end
            idx = $urandom_range(0, remaining.size() - 1);
            pn  = remaining[idx];
            make_packet(gen_frame, pn, pick_length(), -1);
            if (r < 62)
                remaining.delete(idx);
            else
                corrupt_packet();
        end else if (r < 70) begin
            make_packet(gen_frame, $urandom_range(0, dfpr_pkg::PACKETS_PER_FRAME - 1),
                        pick_length(), -1);
        end else if (r < 85) begin
            make_noise($urandom_range(1, dfpr_pkg::HDR_BYTES + dfpr_pkg::CRC_BYTES - 1), -1);
        end else if (r < 90) begin
            make_packet(gen_frame,
                        $urandom_range(0, 1) ? $urandom_range(dfpr_pkg::PACKETS_PER_FRAME, 255)
                                             : $urandom,
                        pick_length(), -1);
        end else if (r < 94) begin
            make_packet(gen_frame - $urandom_range(1, 1 << 20),
                        $urandom_range(0, dfpr_pkg::PACKETS_PER_FRAME - 1), pick_length(), -1);
        end else if (r < 97) begin
            make_packet(gen_frame, $urandom_range(0, dfpr_pkg::PACKETS_PER_FRAME - 1),
                        dfpr_pkg::MAX_PAYLOAD_BYTES, -1);
            add_overflow($urandom_range(1, 6));
        end else begin
            gen_frame = gen_frame + $urandom_range(2, 32'h8000_0000);
            refill_frame();
            idx = $urandom_range(0, remaining.size() - 1);
            make_packet(gen_frame, remaining[idx], pick_length(), -1);
            remaining.delete(idx);
        end
        send_datagram();
    endtask

    initial begin
        int unsigned mark;
        in_if.valid         <= 1'b0;
        in_if.data_byte     <= '0;
        in_if.end_of_packet <= 1'b0;
        i_rst_n             <= 1'b0;
        sent_bytes  = 0;
        in_idle_pct  = 35;
        out_idle_pct = 50;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: short packets, payload extremes, every reject reason, frame compare edges
        make_noise(1, 8'hFF);                           send_datagram();
        make_noise(dfpr_pkg::HDR_BYTES + dfpr_pkg::CRC_BYTES - 1, 8'h00);
        send_datagram();
        make_packet(32'd0, 32'd0, 0, -1);               send_datagram();
        make_packet(32'd0, 32'd15, dfpr_pkg::MAX_PAYLOAD_BYTES, 8'hFF);
        send_datagram();
        make_packet(32'd0, 32'd15, 1, -1);              send_datagram();
        make_packet(32'd0, 32'd3, 5, -1);               send_datagram();
        make_packet(32'd0, 32'd16, 2, -1);              send_datagram();
        make_packet(32'd0, 32'hFFFF_FFFF, 2, -1);       send_datagram();
        make_packet(32'd0, 32'd2, 4, -1);
        corrupt_packet();
        send_datagram();
        make_packet(32'h8000_0001, 32'd1, 2, -1);       send_datagram();
        make_packet(32'h8000_0000, 32'd1, 3, -1);       send_datagram();
        make_packet(32'h7FFF_FFFF, 32'd1, 2, -1);       send_datagram();
        make_packet(32'h8000_0000, 32'd4, dfpr_pkg::MAX_PAYLOAD_BYTES, -1);
        add_overflow(4);
        send_datagram();
        make_packet(32'hFFFF_FFFF, 32'd0, 2, 8'h00);    send_datagram();

        gen_frame = 32'hFFFF_FFFF;
        refill_frame();
        remaining.delete(0);

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                in_idle_pct  = 50;
                out_idle_pct = 35;
            end else if (ph == 2) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            mark = sent_bytes;
            while (sent_bytes - mark < PHASE_BYTES)
                random_datagram();
        end
        in_if.valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
